[sv/stl_pkg.sv]
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types and constants for the source token lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_NUM   = 2'd1,
        MODE_IDENT = 2'd2,
        MODE_OP    = 2'd3
    } mode_t;

    localparam logic [4:0] KIND_NUM      = 5'd14;
    localparam logic [4:0] KIND_IDENT    = 5'd15;
    localparam logic [4:0] KIND_KW_BASE  = 5'd16;
    localparam logic [4:0] KIND_EOF      = 5'd24;
    localparam logic [4:0] KIND_BAD      = 5'd25;
    localparam logic [4:0] KIND_OVERFLOW = 5'd26;
    localparam logic [4:0] KIND_OP_BASE  = 5'd8;

    localparam logic [62:0] VALUE_MAX = {63{1'b1}};
    // at this accumulator only digits up to 7 still fit
    localparam logic [62:0] ACC_SAFE  = 63'd922337203685477580;

    // text of the 14-byte keyword (kind 20)
    localparam logic [111:0] KW_LONG_TEXT = 112'h636865636b5f696e74657276616c;

    typedef struct packed {
        logic [4:0]  kind;
        logic [62:0] value;
        logic [31:0] line;
        logic [31:0] start;
        logic [15:0] len;
        logic        err;
        logic        last;
    } token_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_word(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
            || (c == 8'h5f) || is_digit(c);
    endfunction

    // punctuation index, 8 when not punctuation
    function automatic logic [3:0] punct_index(input logic [7:0] c);
        case (c)
            8'h28:   return 4'd0;
            8'h29:   return 4'd1;
            8'h7b:   return 4'd2;
            8'h7d:   return 4'd3;
            8'h2c:   return 4'd4;
            8'h3b:   return 4'd5;
            8'h2b:   return 4'd6;
            8'h2d:   return 4'd7;
            default: return 4'd8;
        endcase
    endfunction

endpackage

[sv/stl_fifo.sv]
// ----------------------------------------------------------------------------
// stl_fifo
// Small token queue between scanner and output side.
// ----------------------------------------------------------------------------
module stl_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  stl_pkg::token_t wr_data,
    output logic [2:0]      free_cnt,
    input  logic            rd_en,
    output stl_pkg::token_t rd_data,
    output logic            empty
);
    import stl_pkg::*;

    token_t     mem_reg [4];
    logic [1:0] wp_reg;
    logic [1:0] rp_reg;
    logic [2:0] cnt_reg;
    logic [2:0] cnt_next;

    assign cnt_next = cnt_reg + {2'd0, wr_en} - {2'd0, rd_en};
    assign empty    = (cnt_reg == 3'd0);
    assign free_cnt = 3'd4 - cnt_reg;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 2'd0;
            rp_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 2'd1;
            if (rd_en)
                rp_reg <= rp_reg + 2'd1;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

[sv/stl_scan.sv]
// ----------------------------------------------------------------------------
// stl_scan
// Byte classifier and scanner state; produces up to two tokens per byte.
// ----------------------------------------------------------------------------
module stl_scan
#(
    parameter int MAX_KEYWORD_BUFFER = 16
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            take,
    input  logic            cmd,
    input  logic [7:0]      ch,
    output logic [1:0]      tok_cnt,
    output stl_pkg::token_t tok0,
    output stl_pkg::token_t tok1
);
    import stl_pkg::*;

    mode_t       mode_reg,  mode_next;
    logic [1:0]  op_reg,    op_next;
    logic [62:0] acc_reg,   acc_next;
    logic        ovf_reg,   ovf_next;
    logic [15:0] len_reg,   len_next;
    logic [31:0] start_reg, start_next;
    logic [31:0] pos_reg,   pos_next;
    logic [31:0] line_reg,  line_next;
    logic        err_reg,   err_next;
    logic [7:0]  kw_match_reg;
    logic [7:0]  kw_match_next;

    logic [15:0] len_inc;
    logic [3:0]  pidx;
    logic [65:0] acc_x10;
    logic [4:0]  kw_kind;

    // keyword text, indexed [keyword][char]
    function automatic logic [7:0] kw_char(input int k, input int i);
        logic [8*14-1:0] s;
        case (k)
            0:       s = {"if", 96'd0};
            1:       s = {"else", 80'd0};
            2:       s = {"while", 72'd0};
            3:       s = {"input", 72'd0};
            4:       s = KW_LONG_TEXT;
            5:       s = {"nop", 88'd0};
            6:       s = {"call", 80'd0};
            default: s = {"function", 48'd0};
        endcase
        return s[8*(13-i) +: 8];
    endfunction

    function automatic logic [4:0] kw_len(input int k);
        case (k)
            0:       return 5'd2;
            1:       return 5'd4;
            2:       return 5'd5;
            3:       return 5'd5;
            4:       return 5'd14;
            5:       return 5'd3;
            6:       return 5'd4;
            default: return 5'd8;
        endcase
    endfunction

    assign len_inc = (len_reg == 16'hffff) ? len_reg : len_reg + 16'd1;
    assign pidx    = punct_index(ch);
    assign acc_x10 = {3'd0, acc_reg} * 66'd10 + {62'd0, ch[3:0]};

    always_comb
    begin
        kw_kind = KIND_IDENT;
        for (int k = 7; k >= 0; k--)
        begin
            if (kw_match_reg[k] && (len_reg == {11'd0, kw_len(k)})
                && (int'(kw_len(k)) <= MAX_KEYWORD_BUFFER))
                kw_kind = KIND_KW_BASE + 5'(k);
        end
    end

    always_comb
    begin
        token_t flush_tok;
        token_t start_tok;
        logic   has_flush;
        logic   has_start;
        logic   err_f;
        logic   do_start;

        mode_next     = mode_reg;
        op_next       = op_reg;
        acc_next      = acc_reg;
        ovf_next      = ovf_reg;
        len_next      = len_reg;
        start_next    = start_reg;
        pos_next      = pos_reg;
        line_next     = line_reg;
        err_next      = err_reg;
        kw_match_next = kw_match_reg;
        has_flush     = 1'b0;
        has_start     = 1'b0;
        do_start      = 1'b0;
        err_f         = err_reg;
        flush_tok     = '0;
        start_tok     = '0;

        flush_tok.line  = line_reg;
        flush_tok.start = start_reg;
        flush_tok.len   = len_reg;
        case (mode_reg)
            MODE_NUM:
            begin
                flush_tok.kind  = ovf_reg ? KIND_OVERFLOW : KIND_NUM;
                flush_tok.value = acc_reg;
                err_f           = err_reg | ovf_reg;
            end
            MODE_IDENT:
                flush_tok.kind = kw_kind;
            MODE_OP:
            begin
                flush_tok.kind = KIND_OP_BASE + {2'd0, op_reg, 1'b0};
                flush_tok.len  = 16'd1;
            end
            default:
                flush_tok.kind = KIND_EOF;
        endcase
        flush_tok.err = err_f;

        if (cmd)
        begin
            has_flush = (mode_reg != MODE_IDLE);
            mode_next = MODE_IDLE;
            err_next  = err_f;
            start_tok.kind  = KIND_EOF;
            start_tok.line  = line_reg;
            start_tok.start = pos_reg;
            start_tok.err   = err_f;
            has_start = 1'b1;
        end
        else
        begin
            pos_next = pos_reg + 32'd1;
            if ((mode_reg == MODE_NUM) && is_digit(ch))
            begin
                if (acc_reg > ACC_SAFE || (acc_reg == ACC_SAFE && ch[3:0] > 4'd7))
                begin
                    acc_next = VALUE_MAX;
                    ovf_next = 1'b1;
                end
                else
                    acc_next = acc_x10[62:0];
                len_next = len_inc;
            end
            else if ((mode_reg == MODE_IDENT) && is_word(ch))
            begin
                for (int k = 0; k < 8; k++)
                begin
                    if (len_reg < 16'(kw_len(k)) && len_reg < 16'd14)
                    begin
                        if (ch != kw_char(k, int'(len_reg[3:0])))
                            kw_match_next[k] = 1'b0;
                    end
                    else if (len_reg < 16'd14)
                        kw_match_next[k] = 1'b0;
                end
                len_next = len_inc;
            end
            else if ((mode_reg == MODE_OP) && (ch == 8'h3d))
            begin
                start_tok.kind  = KIND_OP_BASE + {2'd0, op_reg, 1'b1};
                start_tok.line  = line_reg;
                start_tok.start = start_reg;
                start_tok.len   = 16'd2;
                start_tok.err   = err_reg;
                has_start       = 1'b1;
                mode_next       = MODE_IDLE;
            end
            else
            begin
                has_flush = (mode_reg != MODE_IDLE);
                mode_next = MODE_IDLE;
                err_next  = err_f;
                do_start  = 1'b1;
            end
        end

        if (do_start)
        begin
            start_tok.line  = line_reg;
            start_tok.start = pos_reg;
            start_tok.len   = 16'd1;
            start_tok.err   = err_f;
            if (pidx != 4'd8)
            begin
                start_tok.kind = {1'b0, pidx};
                has_start      = 1'b1;
            end
            else if (ch == 8'h3d || ch == 8'h3e || ch == 8'h3c)
            begin
                mode_next  = MODE_OP;
                op_next    = (ch == 8'h3d) ? 2'd0 : (ch == 8'h3e) ? 2'd1 : 2'd2;
                start_next = pos_reg;
                len_next   = 16'd1;
            end
            else if (ch == 8'h20 || ch == 8'h09 || ch == 8'h0d)
            begin
                mode_next = MODE_IDLE;
            end
            else if (ch == 8'h0a)
            begin
                if (line_reg != 32'hffffffff)
                    line_next = line_reg + 32'd1;
            end
            else if (is_digit(ch))
            begin
                mode_next  = MODE_NUM;
                acc_next   = {59'd0, ch[3:0]};
                ovf_next   = 1'b0;
                start_next = pos_reg;
                len_next   = 16'd1;
            end
            else if (is_word(ch))
            begin
                mode_next  = MODE_IDENT;
                start_next = pos_reg;
                len_next   = 16'd1;
                for (int k = 0; k < 8; k++)
                    kw_match_next[k] = (ch == kw_char(k, 0));
            end
            else
            begin
                err_next        = 1'b1;
                start_tok.kind  = KIND_BAD;
                start_tok.value = {55'd0, ch};
                start_tok.err   = 1'b1;
                has_start       = 1'b1;
            end
        end

        start_tok.last = 1'b1;
        flush_tok.last = !has_start;
        tok_cnt = {1'b0, has_flush} + {1'b0, has_start};
        tok0    = has_flush ? flush_tok : start_tok;
        tok1    = start_tok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_IDLE;
            op_reg       <= 2'd0;
            acc_reg      <= '0;
            ovf_reg      <= 1'b0;
            len_reg      <= 16'd0;
            start_reg    <= 32'd0;
            pos_reg      <= 32'd0;
            line_reg     <= 32'd1;
            err_reg      <= 1'b0;
            kw_match_reg <= 8'd0;
        end
        else if (take)
        begin
            mode_reg     <= mode_next;
            op_reg       <= op_next;
            acc_reg      <= acc_next;
            ovf_reg      <= ovf_next;
            len_reg      <= len_next;
            start_reg    <= start_next;
            pos_reg      <= pos_next;
            line_reg     <= line_next;
            err_reg      <= err_next;
            kw_match_reg <= kw_match_next;
        end
    end

endmodule

[sv/source_token_lexer.sv]
// ----------------------------------------------------------------------------
// source_token_lexer
// Streaming lexer: one source byte per word, tokens out through a queue.
// ----------------------------------------------------------------------------
// Throughput: one input word per cycle while full is low; a word that yields
// two tokens holds the input while its second token is written.
// A word's first token is written to the queue as the word is taken; a second token is registered and written after it.
// Input stalls (full) while the 4-entry token queue has fewer than two free
// slots or a second token is pending.
// Reset: asynchronous; queue empty, idle, line 1, offset 0.
module source_token_lexer
#(
    parameter int MAX_KEYWORD_BUFFER = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        cmd,
    input  logic [7:0]  ch,
    output logic        empty,
    input  logic        pop,
    output logic [4:0]  token_kind,
    output logic [62:0] number_value,
    output logic [31:0] line_number,
    output logic [31:0] token_start,
    output logic [15:0] token_length,
    output logic        had_error,
    output logic        last
);
    import stl_pkg::*;

    logic       take;
    logic [1:0] tok_cnt;
    token_t     tok0, tok1, head;
    logic [2:0] free_cnt;
    logic       ld_reg;
    token_t     t1_reg;
    logic       rd_en;
    logic       wr_en;
    token_t     wr_data;

    // second token of a word goes in the cycle after the first
    assign full  = (free_cnt < 3'd2) || ld_reg;
    assign take  = push && !full;
    assign wr_en = ld_reg || (take && tok_cnt != 2'd0);
    assign wr_data = ld_reg ? t1_reg : tok0;
    assign rd_en = pop && !empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ld_reg <= 1'b0;
        else
            ld_reg <= take && (tok_cnt == 2'd2);
    end

    always_ff @(posedge clk)
    begin
        t1_reg <= tok1;
    end

    stl_scan #(.MAX_KEYWORD_BUFFER(MAX_KEYWORD_BUFFER)) u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .cmd     (cmd),
        .ch      (ch),
        .tok_cnt (tok_cnt),
        .tok0    (tok0),
        .tok1    (tok1)
    );

    stl_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_data  (wr_data),
        .free_cnt (free_cnt),
        .rd_en    (rd_en),
        .rd_data  (head),
        .empty    (empty)
    );

    assign token_kind   = head.kind;
    assign number_value = head.value;
    assign line_number  = head.line;
    assign token_start  = head.start;
    assign token_length = head.len;
    assign had_error    = head.err;
    assign last         = head.last;

endmodule
